// ===== src/gb3_pkg.sv =====
// shared types, weights and helpers for the 3x3 gaussian blur core
package gb3_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int ROW_W     = 12;
    localparam int MAX_ROWS  = 2048;
    localparam int WEIGHT_W  = 13;
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = PIX_W + WEIGHT_W - FRAC_BITS;
    localparam int SUM_W     = PROD_W + 4;

    typedef logic [PIX_W-1:0]    pix_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef pix_t [2:0][2:0]     window_t;

    typedef enum logic
    {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic valid;
        logic last;
    } tag_t;

    localparam weight_t W_CORNER = 13'd2457;
    localparam weight_t W_EDGE   = 13'd4063;
    localparam weight_t W_CENTRE = 13'd6684;

    // weight of window tap (row, col), row 0 is the oldest line
    function automatic weight_t kernel_weight(input int r, input int c);
        weight_t w;
        if (r == 1 && c == 1)
        begin
            w = W_CENTRE;
        end
        else if (r == 1 || c == 1)
        begin
            w = W_EDGE;
        end
        else
        begin
            w = W_CORNER;
        end
        return w;
    endfunction

    // floored integer part of weight * pixel
    function automatic prod_t weigh(input pix_t p, input weight_t w);
        logic [PIX_W+WEIGHT_W-1:0] full;
        full = (PIX_W + WEIGHT_W)'(p) * (PIX_W + WEIGHT_W)'(w);
        return full[PIX_W+WEIGHT_W-1:FRAC_BITS];
    endfunction

endpackage

// ===== src/gb3_line_mem.sv =====
// dual line buffer memory, one read and one write port, registered read
module gb3_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [2*gb3_pkg::PIX_W-1:0] rd_data,
    input  logic                      we,
    input  logic [AW-1:0]             wr_addr,
    input  logic [2*gb3_pkg::PIX_W-1:0] wr_data
);
    import gb3_pkg::*;

    // upper byte: older line, lower byte: newer line
    logic [2*PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/gb3_kernel.sv =====
// weighted 3x3 sum: product stage then adder stage into the output register
module gb3_kernel (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  gb3_pkg::tag_t         tag_in,
    input  gb3_pkg::window_t      win,
    output logic                  out_valid,
    output logic [gb3_pkg::PIX_W-1:0] blurred,
    output logic                  out_last
);
    import gb3_pkg::*;

    prod_t       prod_reg [9];
    tag_t        tag_reg;
    logic [SUM_W-1:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            out_valid <= 1'b0;
            out_last  <= 1'b0;
        end
        else if (advance)
        begin
            tag_reg   <= tag_in;
            out_valid <= tag_reg.valid;
            out_last  <= tag_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[3*r+c] <= weigh(win[r][c], kernel_weight(r, c));
                end
            end
            blurred <= sum[PIX_W-1:0];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            sum = sum + SUM_W'(prod_reg[i]);
        end
    end

endmodule

// ===== src/gaussian_blur_3x3_core.sv =====
// 3x3 gaussian blur core: position tracking, line buffers, window and output stream
// Takes one 8-bit pixel per clock in raster order and returns the registered blur
// of each interior pixel, in raster order, after the pixel that completes its
// neighborhood; border pixels produce no output and the last interior pixel of a
// frame carries tlast. The sustained rate is one pixel per clock, set by the single
// line-buffer memory (one read and one write each cycle, with a bypass for back to
// back requests on the same column). A stalled output freezes the whole pipeline.
// The line buffers need no clearing after reset; frame size is set through
// frame_rows and frame_cols, clamped to 3..2048 and 3..MAX_COLS.
module gaussian_blur_3x3_core #(
    parameter int MAX_COLS = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // pixel[7:0]
    input  logic                      s_tuser,   // frame_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // blurred[7:0]
    output logic                      m_tlast,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0] cfg_wdata
);
    import gb3_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int AW = $clog2(MAX_COLS);

    logic [CFG_W-1:0] frame_rows_reg;
    logic [CFG_W-1:0] frame_cols_reg;
    logic [CW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;

    logic             advance;
    logic             accept;
    logic [ROW_W-1:0] rows;
    logic [CW-1:0]    cols;
    logic [CFG_W:0]   cols_wide;
    logic [CW-1:0]    col_base;
    logic [ROW_W-1:0] row_base;
    logic [CW-1:0]    col_cur;
    logic [ROW_W-1:0] row_inc;
    logic [ROW_W-1:0] row_cur;
    logic             emit;
    logic             last;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    pix_t             s1_px_reg;
    logic [AW-1:0]    s1_col_reg;
    logic             fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic [2*PIX_W-1:0] rd_data;
    logic [2*PIX_W-1:0] s1_lines;
    pix_t             s1_top;
    pix_t             s1_mid;
    logic             fwd_hit;

    window_t          win_reg;
    tag_t             s2_tag_reg;

    assign advance = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept  = s_tvalid && advance;

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= 12'd1080;
            frame_cols_reg <= 12'd1920;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_ROWS: frame_rows_reg <= cfg_wdata;
                REG_FRAME_COLS: frame_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped frame size and position of the incoming pixel
    always_comb
    begin
        priority if (frame_rows_reg < ROW_W'(3))
        begin
            rows = ROW_W'(3);
        end
        else if (frame_rows_reg > ROW_W'(MAX_ROWS))
        begin
            rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows = frame_rows_reg;
        end

        cols_wide = {1'b0, frame_cols_reg};
        priority if (cols_wide < (CFG_W + 1)'(3))
        begin
            cols = CW'(3);
        end
        else if (cols_wide > (CFG_W + 1)'(MAX_COLS))
        begin
            cols = CW'(MAX_COLS);
        end
        else
        begin
            cols = CW'(cols_wide);
        end

        col_base = s_tuser ? '0 : col_count_reg;
        row_base = s_tuser ? '0 : row_count_reg;

        if (col_base >= cols)
        begin
            col_cur = '0;
            row_inc = row_base + ROW_W'(1);
        end
        else
        begin
            col_cur = col_base;
            row_inc = row_base;
        end
        row_cur = (row_inc >= rows) ? '0 : row_inc;

        emit = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
        last = (row_cur == rows - ROW_W'(1)) && (col_cur == cols - CW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_cur + CW'(1);
            row_count_reg <= row_cur;
        end
    end

    // line buffer read stage with bypass of the previous request's write
    assign fwd_hit  = s1_valid_reg && (s1_col_reg == col_cur[AW-1:0]);
    assign s1_lines = fwd_reg ? fwd_data_reg : rd_data;
    assign s1_top   = s1_lines[2*PIX_W-1:PIX_W];
    assign s1_mid   = s1_lines[PIX_W-1:0];

    gb3_line_mem #(
        .DEPTH (MAX_COLS),
        .AW    (AW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur[AW-1:0]),
        .rd_data (rd_data),
        .we      (advance && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_mid, s1_px_reg})
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s_tvalid;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            fwd_reg      <= fwd_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_px_reg    <= s_tdata;
            s1_col_reg   <= col_cur[AW-1:0];
            fwd_data_reg <= {s1_mid, s1_px_reg};
        end
    end

    // sliding window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            s2_tag_reg <= '0;
        end
        else if (advance)
        begin
            s2_tag_reg.valid <= s1_valid_reg && s1_emit_reg;
            s2_tag_reg.last  <= s1_last_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= s1_top;
                win_reg[1][2] <= s1_mid;
                win_reg[2][2] <= s1_px_reg;
            end
        end
    end

    gb3_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tag_in    (s2_tag_reg),
        .win       (win_reg),
        .out_valid (m_tvalid),
        .blurred   (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser |=> col_count_reg == CW'(1) && row_count_reg == '0)
        else $error("frame start did not restart position at the origin");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg <= CW'(MAX_COLS))
        else $error("column counter beyond line length");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg < ROW_W'(MAX_ROWS))
        else $error("row counter beyond frame height");
`endif

endmodule

// ===== tb/tb_gaussian_blur_3x3_core.sv =====
// testbench for the 3x3 gaussian blur core: predicted blur values checked against the output stream
`timescale 1ns / 100ps

module tb_gaussian_blur_3x3_core;

    import gb3_pkg::*;

    localparam int          MAX_COLS      = 2048;
    localparam int          FRAME_MAXR    = 2048;
    localparam int unsigned K_CORNER      = 2457;
    localparam int unsigned K_EDGE        = 4063;
    localparam int unsigned K_CENTRE      = 6684;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          MAX_REPORTS   = 10;

    typedef struct packed
    {
        pix_t blurred;
        logic last;
    } blur_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    pix_t             s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    pix_t             m_tdata;
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    cfg_reg_t         cfg_index = REG_FRAME_ROWS;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // predictor copy of the block
    pix_t             line_mem [0:2*MAX_COLS-1];
    pix_t             win [0:2][0:2];
    int unsigned      row_pos = 0;
    int unsigned      col_pos = 0;
    logic [CFG_W-1:0] rows_reg = 12'd1080;
    logic [CFG_W-1:0] cols_reg = 12'd1920;

    blur_t            blur_q [$];
    int               mismatches  = 0;
    int               send_idle   = 0;
    int               recv_idle   = 0;
    logic             hold_ready  = 1'b0;
    logic             restart_due = 1'b0;

    gaussian_blur_3x3_core #(
        .MAX_COLS (MAX_COLS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 3)
        begin
            return 3;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void predict_blur(input pix_t px, input logic start);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned sum;
        int unsigned wt;
        pix_t        top;
        pix_t        mid;
        blur_t       res;
        nrows = clamp_size(rows_reg, FRAME_MAXR);
        ncols = clamp_size(cols_reg, MAX_COLS);
        if (start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= ncols)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= nrows)
        begin
            row_pos = 0;
        end
        top = line_mem[col_pos];
        mid = line_mem[MAX_COLS + col_pos];
        line_mem[col_pos] = mid;
        line_mem[MAX_COLS + col_pos] = px;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            sum = 0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (r == 1 && k == 1)
                    begin
                        wt = K_CENTRE;
                    end
                    else if (r == 1 || k == 1)
                    begin
                        wt = K_EDGE;
                    end
                    else
                    begin
                        wt = K_CORNER;
                    end
                    sum += (wt * win[r][k]) >> FRAC_BITS;
                end
            end
            res.blurred = pix_t'(sum);
            res.last    = (row_pos == nrows - 1) && (col_pos == ncols - 1);
            blur_q.push_back(res);
        end
        col_pos++;
    endfunction

    function automatic pix_t rand_pixel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size(input logic for_rows);
        int v;
        v = $urandom_range(99);
        if (v < 8)
        begin
            return CFG_W'($urandom_range(2));
        end
        if (for_rows && v < 11)
        begin
            return CFG_W'($urandom_range(4095, 2049));
        end
        if (for_rows && v < 13)
        begin
            return 12'hFFF;
        end
        if (for_rows)
        begin
            return CFG_W'($urandom_range(8, 3));
        end
        return CFG_W'($urandom_range(14, 3));
    endfunction

    // one pixel request, returns at the edge that accepts it
    task automatic send_pixel(input pix_t px, input logic start);
        logic first;
        first       = start | restart_due;
        restart_due = 1'b0;
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        predict_blur(px, first);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (blur_q.size() != 0)
        begin
            @(posedge clk);
        end
        hold_ready <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        hold_ready <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_COLS)
        begin
            // wider rows would read line entries never written, so restart the frame
            if (clamp_size(val, MAX_COLS) > clamp_size(cols_reg, MAX_COLS))
            begin
                restart_due = 1'b1;
            end
            cols_reg = val;
        end
        else
        begin
            rows_reg = val;
        end
    endtask

    task automatic configure(input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
        settle();
        write_reg(REG_FRAME_ROWS, nrows);
        write_reg(REG_FRAME_COLS, ncols);
    endtask

    always @(posedge clk)
    begin : check_output
        blur_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (blur_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected result: blurred=%0d last=%0b", m_tdata, m_tlast);
                end
            end
            else
            begin
                want = blur_q.pop_front();
                if (m_tdata !== want.blurred || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected blurred=%0d last=%0b, got blurred=%0d last=%0b",
                                 want.blurred, want.last, m_tdata, m_tlast);
                    end
                end
            end
        end
        m_tready <= hold_ready || ($urandom_range(99) >= recv_idle);
    end

    task automatic test_reset_size();
        for (int i = 0; i < 12; i++)
        begin
            send_pixel(rand_pixel(), 1'b0);
        end
    endtask

    task automatic test_pixel_extremes();
        configure(12'd3, 12'd3);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel(8'hFF, i == 0);
        end
        // row wrap into the next frame, checkerboard
        for (int i = 0; i < 9; i++)
        begin
            send_pixel((i % 2) ? 8'h00 : 8'hFF, 1'b0);
        end
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hFE, 1'b1);
        send_pixel(8'h7F, 1'b0);
    endtask

    task automatic test_size_extremes();
        configure(12'd0, 12'hFFF);
        for (int i = 0; i < 60; i++)
        begin
            send_pixel(rand_pixel(), i == 0);
        end
        configure(12'd2048, 12'd2);
        for (int i = 0; i < 150; i++)
        begin
            send_pixel(rand_pixel(), i == 0);
        end
    endtask

    task automatic test_random_stream(input int n_items, input int tx_idle, input int rx_idle);
        int unsigned nrows;
        int unsigned ncols;
        int          sent;
        int          len;
        int          pick;
        logic        first;
        send_idle = tx_idle;
        recv_idle = rx_idle;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                // size change, possibly in the middle of a frame
                settle();
                if ($urandom_range(3) != 0)
                begin
                    write_reg(REG_FRAME_ROWS, pick_size(1'b1));
                end
                if ($urandom_range(3) != 0)
                begin
                    write_reg(REG_FRAME_COLS, pick_size(1'b0));
                end
            end
            else
            begin
                nrows = clamp_size(rows_reg, FRAME_MAXR);
                ncols = clamp_size(cols_reg, MAX_COLS);
                len   = nrows * ncols;
                if (pick < 93 && len > 400)
                begin
                    len   = $urandom_range(60, 1);
                    first = 1'b1;
                end
                else if (pick < 77)
                begin
                    first = 1'b1;
                end
                else if (pick < 85)
                begin
                    first = 1'b0;
                end
                else if (pick < 93)
                begin
                    len   = $urandom_range(len - 1, 1);
                    first = 1'b1;
                end
                else
                begin
                    len   = $urandom_range(20, 1);
                    first = 1'b0;
                end
                for (int i = 0; i < len; i++)
                begin
                    if (pick >= 93)
                    begin
                        send_pixel(rand_pixel(), $urandom_range(7) == 0);
                    end
                    else
                    begin
                        send_pixel(rand_pixel(), first && i == 0);
                    end
                end
                sent += len;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 2 * MAX_COLS; i++)
        begin
            line_mem[i] = '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win[r][k] = '0;
            end
        end
        send_idle = 30;
        recv_idle = 45;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_pixel_extremes();
        test_size_extremes();
        test_random_stream(360, 30, 45);
        test_random_stream(360, 45, 30);
        test_random_stream(360, 0, 0);

        settle();
        if (mismatches == 0 && blur_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
